FILE: rtl/bse_pkg.sv
// Shared constants, types and curve tables for the battery SOC estimator.
// No dependencies; used by every module of the block.
`default_nettype none
package bse_pkg;

  localparam int WINDOW_DEPTH = 50;
  localparam int CURVE_POINTS = 21;

  localparam int TIME_W  = 32;
  localparam int PACK_W  = 17;
  localparam int CELLS_W = 6;
  localparam int IVL_W   = 16;
  localparam int SOC_W   = 7;
  localparam int FRAC_W  = 8;
  localparam int MV_W    = 12;

  localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);
  localparam int ADDR_W    = $clog2(WINDOW_DEPTH);
  localparam int SUM_W     = PACK_W + CNT_W;
  localparam int DVD_W     = SUM_W + FRAC_W;
  localparam int PT_W      = MV_W + FRAC_W;
  localparam int DVS_W     = PT_W + 1;
  localparam int DEN_W     = CNT_W + CELLS_W;
  localparam int DIV_CNT_W = $clog2(DVD_W);
  localparam int SEG_W     = $clog2(CURVE_POINTS);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SERIES_CELLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN     = 2'd2;

  localparam logic [CELLS_W-1:0] CELLS_RESET = 6'd5;
  localparam logic [CELLS_W-1:0] CELLS_MIN   = 6'd1;
  localparam logic [CELLS_W-1:0] CELLS_MAX   = 6'd32;
  localparam logic [IVL_W-1:0]   INTERVAL_RESET = 16'd100;
  localparam logic [IVL_W-1:0]   COOLDOWN_RESET = 16'd2000;
  localparam logic [SOC_W-1:0]   SOC_MAX = 7'd100;

  localparam logic [SEG_W-1:0] SEG_FIRST = '0;
  localparam logic [SEG_W-1:0] SEG_LAST  = SEG_W'(CURVE_POINTS - 1);

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [PACK_W-1:0] wdata;
  } ring_req_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  // Li-ion cell voltage curve points, whole mV.
  function automatic logic [MV_W-1:0] curve_mv(input logic [SEG_W-1:0] idx);
    logic [MV_W-1:0] v;
    case (idx)
      5'd0:    v = 12'd3520;
      5'd1:    v = 12'd3534;
      5'd2:    v = 12'd3549;
      5'd3:    v = 12'd3568;
      5'd4:    v = 12'd3590;
      5'd5:    v = 12'd3626;
      5'd6:    v = 12'd3662;
      5'd7:    v = 12'd3687;
      5'd8:    v = 12'd3711;
      5'd9:    v = 12'd3737;
      5'd10:   v = 12'd3762;
      5'd11:   v = 12'd3787;
      5'd12:   v = 12'd3811;
      5'd13:   v = 12'd3834;
      5'd14:   v = 12'd3852;
      5'd15:   v = 12'd3878;
      5'd16:   v = 12'd3896;
      5'd17:   v = 12'd3922;
      5'd18:   v = 12'd3951;
      5'd19:   v = 12'd3990;
      5'd20:   v = 12'd4080;
      default: v = 12'd4080;
    endcase
    return v;
  endfunction

  // SOC percent at each curve point.
  function automatic logic [SOC_W-1:0] curve_soc(input logic [SEG_W-1:0] idx);
    logic [SOC_W-1:0] s;
    case (idx)
      5'd0:    s = 7'd0;
      5'd1:    s = 7'd5;
      5'd2:    s = 7'd10;
      5'd3:    s = 7'd15;
      5'd4:    s = 7'd20;
      5'd5:    s = 7'd25;
      5'd6:    s = 7'd30;
      5'd7:    s = 7'd35;
      5'd8:    s = 7'd40;
      5'd9:    s = 7'd45;
      5'd10:   s = 7'd50;
      5'd11:   s = 7'd55;
      5'd12:   s = 7'd60;
      5'd13:   s = 7'd65;
      5'd14:   s = 7'd70;
      5'd15:   s = 7'd75;
      5'd16:   s = 7'd80;
      5'd17:   s = 7'd85;
      5'd18:   s = 7'd90;
      5'd19:   s = 7'd95;
      5'd20:   s = 7'd100;
      default: s = 7'd100;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/bse_ring.sv
// Sample ring memory: one read or write port per cycle, registered read data.
// Depends on bse_pkg.
`default_nettype none
module bse_ring (
  input  wire logic                       clk,
  input  wire bse_pkg::ring_req_t         req,
  output logic [bse_pkg::PACK_W-1:0]      rdata
);

  logic [bse_pkg::PACK_W-1:0] mem [bse_pkg::WINDOW_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata <= mem[req.addr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bse_div.sv
// Restoring divider, one quotient bit per cycle, shared by the averaging
// and interpolation steps. Depends on bse_pkg.
`default_nettype none
module bse_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bse_pkg::div_req_t req,
  output bse_pkg::div_rsp_t      rsp
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [bse_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [bse_pkg::DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [bse_pkg::DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [bse_pkg::DVS_W-1:0]     rem_r, rem_nxt;
  logic [bse_pkg::DVS_W:0]       rem_sh;
  logic [bse_pkg::DVS_W:0]       diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    rem_sh   = {rem_r, dvd_r[bse_pkg::DVD_W-1]};
    diff     = rem_sh - {1'b0, dvs_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // quotient bits shift in where dividend bits leave
      if (!diff[bse_pkg::DVS_W]) begin
        rem_nxt = diff[bse_pkg::DVS_W-1:0];
        dvd_nxt = {dvd_r[bse_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[bse_pkg::DVS_W-1:0];
        dvd_nxt = {dvd_r[bse_pkg::DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + bse_pkg::DIV_CNT_W'(1);
      if (cnt_r == bse_pkg::DIV_CNT_W'(bse_pkg::DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule
`default_nettype wire

FILE: rtl/battery_soc_estimator_core.sv
// Battery state-of-charge estimator, top level.
// Depends on bse_pkg, bse_ring and bse_div.
`default_nettype none
// Each update request (time, motor flag, ready flag, pack mV) returns one SOC
// result. Samples go into a 50-entry ring memory with a running sum; while the
// motor runs nothing is sampled, and after it stops sampling waits out the
// cooldown. Every item passes a control state, plus a ring write-back state
// when a sample is taken into a full ring. With no samples stored the result
// follows right away. Otherwise the shared one-bit-per-cycle divider (31
// steps) forms the average cell voltage. An average at or past either end of
// the curve ends there. Anything else goes through a scan of the curve, one
// segment per cycle (up to 20 visited), and a second division for the
// interpolation. One item is worked on at a time; a new request is taken in
// the cycle after the previous result has moved to the output register, even
// if that result is still stalled. No clearing pass after reset. Config
// writes are to be issued only while the block is idle.
module battery_soc_estimator_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [bse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bse_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // update requests
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [bse_pkg::TIME_W-1:0]       in_now_ms,
  input  wire logic                             in_motor_active,
  input  wire logic                             in_battery_ready,
  input  wire logic [bse_pkg::PACK_W-1:0]       in_pack_mv,
  // results
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [bse_pkg::SOC_W-1:0]             out_soc_percent,
  output logic                                  out_has_samples,
  output logic                                  out_reading_valid,
  output logic                                  out_sample_taken
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CTRL  = 4'd1;  // sampling decision, ring access
  localparam logic [3:0] S_WB    = 4'd2;  // full ring: replace oldest
  localparam logic [3:0] S_DSET  = 4'd3;  // start average division
  localparam logic [3:0] S_DWAIT = 4'd4;
  localparam logic [3:0] S_CLS   = 4'd5;  // check curve ends
  localparam logic [3:0] S_SEG   = 4'd6;  // segment scan
  localparam logic [3:0] S_ISET  = 4'd7;  // start interpolation division
  localparam logic [3:0] S_IWAIT = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  // config registers
  logic [bse_pkg::CELLS_W-1:0] series_r;
  logic [bse_pkg::IVL_W-1:0]   interval_r;
  logic [bse_pkg::IVL_W-1:0]   cooldown_r;
  logic [bse_pkg::CELLS_W-1:0] cells_wr;

  // latched request
  logic [bse_pkg::TIME_W-1:0] now_r;
  logic                       motor_r;
  logic                       ready_r;
  logic [bse_pkg::PACK_W-1:0] mv_r;

  // estimator state
  logic [3:0]                 state_r, state_nxt;
  logic [bse_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [bse_pkg::ADDR_W-1:0] oldest_r, oldest_nxt;
  logic [bse_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic                       was_run_r, was_run_nxt;
  logic [bse_pkg::TIME_W-1:0] due_r, due_nxt;
  logic                       taken_r, taken_nxt;
  logic [bse_pkg::DVD_W-1:0]  c_r, c_nxt;
  logic [bse_pkg::SEG_W-1:0]  seg_r, seg_nxt;
  logic [bse_pkg::SOC_W-1:0]  soc_r, soc_nxt;

  // output register
  logic                       out_valid_r, out_valid_nxt;
  logic [bse_pkg::SOC_W-1:0]  out_soc_r;
  logic                       out_has_r;
  logic                       out_rv_r;
  logic                       out_taken_r;
  logic                       out_load;

  bse_pkg::ring_req_t         ring_req;
  logic [bse_pkg::PACK_W-1:0] ring_rdata;
  bse_pkg::div_req_t          div_req;
  bse_pkg::div_rsp_t          div_rsp;

  // datapath temporaries
  logic [bse_pkg::TIME_W-1:0] due_base;
  logic [bse_pkg::TIME_W-1:0] elapsed;
  logic [bse_pkg::DEN_W-1:0]  den;
  logic [bse_pkg::SEG_W-1:0]  seg_next_pt;
  logic [bse_pkg::MV_W-1:0]   v0, v1;
  logic [bse_pkg::PT_W-1:0]   seg_d;
  logic [bse_pkg::PT_W-1:0]   seg_off;
  logic [bse_pkg::SOC_W-1:0]  seg_ds;
  logic [bse_pkg::DVD_W-1:0]  num;
  logic [bse_pkg::DVD_W-1:0]  soc_sum;

  logic in_accept;

  bse_ring u_ring (
    .clk   (clk),
    .req   (ring_req),
    .rdata (ring_rdata)
  );

  bse_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // no request is taken while reset is held
  assign in_stall  = (state_r != S_IDLE) || !rst_n;
  assign in_accept = in_valid && !in_stall;

  // series cell count is clamped to 1..32 on write
  always_comb begin
    cells_wr = cfg_wdata[bse_pkg::CELLS_W-1:0];
    if (cells_wr < bse_pkg::CELLS_MIN) begin
      cells_wr = bse_pkg::CELLS_MIN;
    end else if (cells_wr > bse_pkg::CELLS_MAX) begin
      cells_wr = bse_pkg::CELLS_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      series_r   <= bse_pkg::CELLS_RESET;
      interval_r <= bse_pkg::INTERVAL_RESET;
      cooldown_r <= bse_pkg::COOLDOWN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bse_pkg::CFG_SERIES_CELLS: series_r   <= cells_wr;
        bse_pkg::CFG_INTERVAL:     interval_r <= cfg_wdata[bse_pkg::IVL_W-1:0];
        bse_pkg::CFG_COOLDOWN:     cooldown_r <= cfg_wdata[bse_pkg::IVL_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // curve segment operands
  assign seg_next_pt = seg_r + bse_pkg::SEG_W'(1);
  assign v0          = bse_pkg::curve_mv(seg_r);
  assign v1          = bse_pkg::curve_mv(seg_next_pt);
  assign seg_d       = {v1 - v0, bse_pkg::FRAC_W'(0)};
  // c lies above v0 and not above v1 of the segment, so its low bits carry the offset
  assign seg_off     = c_r[bse_pkg::PT_W-1:0] - {v0, bse_pkg::FRAC_W'(0)};
  assign seg_ds      = bse_pkg::curve_soc(seg_next_pt) - bse_pkg::curve_soc(seg_r);
  // 2*ds*(c - v0) + d, divided by 2*d gives the rounded step
  assign num         = bse_pkg::DVD_W'({seg_ds, 1'b0}) * bse_pkg::DVD_W'(seg_off)
                     + bse_pkg::DVD_W'(seg_d);
  assign soc_sum     = bse_pkg::DVD_W'(bse_pkg::curve_soc(seg_r)) + div_rsp.quotient;

  assign den      = bse_pkg::DEN_W'(count_r) * bse_pkg::DEN_W'(series_r);
  // motor just stopped: cooldown deadline replaces the stored one
  assign due_base = was_run_r ? now_r + bse_pkg::TIME_W'(cooldown_r) : due_r;
  assign elapsed  = now_r - due_base;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    oldest_nxt  = oldest_r;
    sum_nxt     = sum_r;
    was_run_nxt = was_run_r;
    due_nxt     = due_r;
    taken_nxt   = taken_r;
    c_nxt       = c_r;
    seg_nxt     = seg_r;
    soc_nxt     = soc_r;
    out_load    = 1'b0;

    ring_req.wr_en = 1'b0;
    ring_req.rd_en = 1'b0;
    ring_req.addr  = oldest_r;
    ring_req.wdata = mv_r;

    div_req.start    = 1'b0;
    div_req.dividend = {sum_r, bse_pkg::FRAC_W'(0)};
    div_req.divisor  = bse_pkg::DVS_W'(den);

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_CTRL;
        end
      end
      S_CTRL: begin
        taken_nxt = 1'b0;
        state_nxt = S_DSET;
        if (motor_r) begin
          was_run_nxt = 1'b1;
        end else begin
          was_run_nxt = 1'b0;
          due_nxt     = due_base;
          if (!elapsed[bse_pkg::TIME_W-1]) begin
            due_nxt = now_r + bse_pkg::TIME_W'(interval_r);
            if (ready_r) begin
              taken_nxt = 1'b1;
              if (count_r != bse_pkg::CNT_W'(bse_pkg::WINDOW_DEPTH)) begin
                ring_req.wr_en = 1'b1;
                ring_req.addr  = count_r[bse_pkg::ADDR_W-1:0];
                sum_nxt        = sum_r + bse_pkg::SUM_W'(mv_r);
                count_nxt      = count_r + bse_pkg::CNT_W'(1);
              end else begin
                // fetch the oldest sample to take it out of the sum
                ring_req.rd_en = 1'b1;
                state_nxt      = S_WB;
              end
            end
          end
        end
      end
      S_WB: begin
        ring_req.wr_en = 1'b1;
        sum_nxt = sum_r - bse_pkg::SUM_W'(ring_rdata) + bse_pkg::SUM_W'(mv_r);
        if (oldest_r == bse_pkg::ADDR_W'(bse_pkg::WINDOW_DEPTH - 1)) begin
          oldest_nxt = '0;
        end else begin
          oldest_nxt = oldest_r + bse_pkg::ADDR_W'(1);
        end
        state_nxt = S_DSET;
      end
      S_DSET: begin
        if (count_r == '0) begin
          soc_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (div_rsp.done) begin
          c_nxt     = div_rsp.quotient;
          state_nxt = S_CLS;
        end
      end
      S_CLS: begin
        seg_nxt = bse_pkg::SEG_FIRST;
        if (c_r >= bse_pkg::DVD_W'({bse_pkg::curve_mv(bse_pkg::SEG_LAST),
                                     bse_pkg::FRAC_W'(0)})) begin
          soc_nxt   = bse_pkg::curve_soc(bse_pkg::SEG_LAST);
          state_nxt = S_DONE;
        end else if (c_r <= bse_pkg::DVD_W'({bse_pkg::curve_mv(bse_pkg::SEG_FIRST),
                                            bse_pkg::FRAC_W'(0)})) begin
          soc_nxt   = bse_pkg::curve_soc(bse_pkg::SEG_FIRST);
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SEG;
        end
      end
      S_SEG: begin
        // first segment whose upper point is not below c
        if (c_r <= bse_pkg::DVD_W'({v1, bse_pkg::FRAC_W'(0)})) begin
          state_nxt = S_ISET;
        end else begin
          seg_nxt = seg_next_pt;
        end
      end
      S_ISET: begin
        div_req.start    = 1'b1;
        div_req.dividend = num;
        div_req.divisor  = {seg_d, 1'b0};
        state_nxt        = S_IWAIT;
      end
      S_IWAIT: begin
        if (div_rsp.done) begin
          if (soc_sum > bse_pkg::DVD_W'(bse_pkg::SOC_MAX)) begin
            soc_nxt = bse_pkg::SOC_MAX;
          end else begin
            soc_nxt = soc_sum[bse_pkg::SOC_W-1:0];
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      oldest_r    <= '0;
      sum_r       <= '0;
      was_run_r   <= 1'b0;
      due_r       <= bse_pkg::TIME_W'(bse_pkg::INTERVAL_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      oldest_r    <= oldest_nxt;
      sum_r       <= sum_nxt;
      was_run_r   <= was_run_nxt;
      due_r       <= due_nxt;
      out_valid_r <= out_valid_nxt;
    end
    taken_r <= taken_nxt;
    c_r     <= c_nxt;
    seg_r   <= seg_nxt;
    soc_r   <= soc_nxt;
    if (in_accept) begin
      now_r   <= in_now_ms;
      motor_r <= in_motor_active;
      ready_r <= in_battery_ready;
      mv_r    <= in_pack_mv;
    end
    if (out_load) begin
      out_soc_r   <= soc_r;
      out_has_r   <= (count_r != '0);
      out_rv_r    <= (count_r != '0) && !motor_r;
      out_taken_r <= taken_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_soc_percent   = out_soc_r;
  assign out_has_samples   = out_has_r;
  assign out_reading_valid = out_rv_r;
  assign out_sample_taken  = out_taken_r;

endmodule
`default_nettype wire
